>>> rtl/core/bait_pkg.sv
// Shared types, constants and codes for the binned adaptive intensity threshold.
// No dependencies; imported by every module of the block but bait_fifo.
`default_nettype none

package bait_pkg;

  localparam int LAYERS_DEF           = 32;
  localparam int RANGE_BINS_DEF       = 16;
  localparam int MAX_FRAME_POINTS_DEF = 65536;

  localparam int CFG_ADDR_W = 3;
  localparam int CFG_DATA_W = 24;
  localparam int CELL_IDX_W = 16;   // cell field of a queued job, wide enough for up to 65536 cells
  localparam int QUEUE_DEPTH = 4;
  localparam int OUT_DEPTH   = 2;
  localparam int EPOCH_W     = 8;

  localparam int MIN_BIN_MM    = 50;
  localparam int STD_MIN_COUNT = 2;
  localparam int MEAN_W = 24;
  localparam int VAR_W  = 48;
  localparam int STD_W  = 24;
  localparam int KS_W   = 28;
  localparam int THR_W  = 29;
  localparam int SCORE_W = 25;

  localparam logic [15:0] RST_RANGE_BIN_SIZE = 16'd500;
  localparam logic [11:0] RST_STDDEV_GAIN    = 12'd384;
  localparam logic [23:0] RST_MIN_DELTA      = 24'd1280;
  localparam logic [15:0] RST_MIN_BIN_SAMP   = 16'd20;
  localparam logic [23:0] RST_FLOOR          = 24'd0;
  localparam logic        RST_BIN_BY_LAYER   = 1'b1;
  localparam logic        RST_BOOST_EN       = 1'b1;
  localparam logic [23:0] RST_BOOST_AMOUNT   = 24'd6400;

  typedef enum logic [1:0] {
    OP_CLEAR    = 2'd0,
    OP_ACCUM    = 2'd1,
    OP_CLASSIFY = 2'd2,
    OP_NONE     = 2'd3
  } op_e;

  typedef enum logic [CFG_ADDR_W-1:0] {
    REG_RANGE_BIN_SIZE = 3'd0,
    REG_STDDEV_GAIN    = 3'd1,
    REG_MIN_DELTA      = 3'd2,
    REG_MIN_BIN_SAMP   = 3'd3,
    REG_FLOOR          = 3'd4,
    REG_BIN_BY_LAYER   = 3'd5,
    REG_BOOST_EN       = 3'd6,
    REG_BOOST_AMOUNT   = 3'd7
  } cfg_reg_e;

  typedef struct packed {
    logic [1:0]  opcode;
    logic [15:0] intensity;
    logic [15:0] range_mm;
    logic [4:0]  layer;
    logic        layer_known;
    logic        reflector;
  } item_t;

  typedef struct packed {
    logic               passed;
    logic [SCORE_W-1:0] score;
    logic               used_bin_stats;
  } result_t;

  typedef struct packed {
    logic [15:0] range_bin_size_mm;
    logic [11:0] stddev_gain;
    logic [23:0] min_delta;
    logic [15:0] min_bin_samples;
    logic [23:0] intensity_floor;
    logic        bin_by_layer;
    logic        boost_enable;
    logic [23:0] boost_amount;
  } cfg_t;

  typedef struct packed {
    op_e                   op;
    logic [15:0]           intensity;
    logic [CELL_IDX_W-1:0] cell_idx;
    logic                  reflector;
  } job_t;

  typedef enum logic [1:0] {
    F_IDLE,
    F_DIV,
    F_PUSH
  } front_state_e;

  typedef enum logic [3:0] {
    B_WIPE,
    B_IDLE,
    B_READ,
    B_MEAN,
    B_MSQ,
    B_SQR,
    B_VAR,
    B_SQRT,
    B_KS,
    B_THR,
    B_OUT
  } back_state_e;

endpackage

`default_nettype wire

>>> rtl/core/bait_fifo.sv
// Small synchronous FIFO of any packed type, used between front and back and at the output.
// Depends on nothing but its parameters.
`default_nettype none

module bait_fifo #(
  parameter type T     = logic,
  parameter int  DEPTH = 4
) (
  input  wire  clk,
  input  wire  rst,
  input  wire  wr_en,
  input  T     din,
  output logic full,
  input  wire  rd_en,
  output T     dout,
  output logic empty
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  T mem [DEPTH];
  logic [AW:0] wptr;
  logic [AW:0] rptr;

  assign empty = (wptr == rptr);
  assign full  = (wptr[AW-1:0] == rptr[AW-1:0]) && (wptr[AW] != rptr[AW]);
  assign dout  = mem[rptr[AW-1:0]];

  always_ff @(posedge clk) begin
    if (wr_en && !full) begin
      mem[wptr[AW-1:0]] <= din;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr <= '0;
      rptr <= '0;
    end else begin
      if (wr_en && !full) begin
        wptr <= wptr + 1'b1;
      end
      if (rd_en && !empty) begin
        rptr <= rptr + 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

>>> rtl/core/bait_front.sv
// Front end: takes input items, drops unused opcodes and works out the statistics cell.
// Uses bait_pkg; feeds the job queue toward bait_back.
`default_nettype none

module bait_front #(
  parameter int LAYERS     = bait_pkg::LAYERS_DEF,
  parameter int RANGE_BINS = bait_pkg::RANGE_BINS_DEF
) (
  input  wire            clk,
  input  wire            rst,
  input  wire            push,
  output logic           full,
  input  bait_pkg::item_t item,
  input  bait_pkg::cfg_t  cfg,
  output logic           q_wr,
  output bait_pkg::job_t q_din,
  input  wire            q_full
);
  import bait_pkg::*;

  front_state_e state, state_next;
  item_t        cur;
  logic [15:0]  x;
  logic [16:0]  rem;
  logic [15:0]  dsr;
  logic [4:0]   cnt;

  logic [16:0] rs;
  logic        ge;
  logic [31:0] lb32, rb32, cell32;

  // restoring divide of range by bin size, one quotient bit per cycle
  assign rs = {rem[15:0], x[15]};
  assign ge = (rs >= {1'b0, dsr});

  always_comb begin
    lb32 = (cfg.bin_by_layer && cur.layer_known) ? 32'(cur.layer) : 32'd0;
    if (lb32 > 32'(LAYERS - 1)) lb32 = 32'(LAYERS - 1);
    rb32 = 32'(x);
    if (rb32 > 32'(RANGE_BINS - 1)) rb32 = 32'(RANGE_BINS - 1);
    cell32 = lb32 * 32'(RANGE_BINS) + rb32;
  end

  always_comb begin
    state_next = state;
    full       = 1'b1;
    q_wr       = 1'b0;
    q_din.op        = op_e'(cur.opcode);
    q_din.intensity = cur.intensity;
    q_din.cell_idx  = CELL_IDX_W'(cell32);
    q_din.reflector = cur.reflector;
    unique case (state)
      F_IDLE: begin
        full = 1'b0;
        if (push) begin
          unique case (op_e'(item.opcode))
            OP_CLEAR:              state_next = F_PUSH;
            OP_ACCUM, OP_CLASSIFY: state_next = F_DIV;
            OP_NONE:               state_next = F_IDLE;
          endcase
        end
      end
      F_DIV: begin
        if (cnt == 5'd1) state_next = F_PUSH;
      end
      F_PUSH: begin
        q_wr = !q_full;
        if (!q_full) state_next = F_IDLE;
      end
      default: state_next = F_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= F_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (state == F_IDLE && push) begin
      cur <= item;
      x   <= item.range_mm;
      rem <= '0;
      cnt <= 5'd16;
      dsr <= (cfg.range_bin_size_mm < 16'(MIN_BIN_MM)) ? 16'(MIN_BIN_MM)
                                                       : cfg.range_bin_size_mm;
    end else if (state == F_DIV) begin
      rem <= ge ? (rs - {1'b0, dsr}) : rs;
      x   <= {x[14:0], ge};
      cnt <= cnt - 5'd1;
    end
  end

endmodule

`default_nettype wire

>>> rtl/core/bait_arith.sv
// Shared iterative unit: restoring divider (one bit a cycle) and integer square root
// (one root bit a cycle). Uses bait_pkg for the root widths.
`default_nettype none

module bait_arith #(
  parameter int CNT_W = 17,
  parameter int DVD_W = 65
) (
  input  wire               clk,
  input  wire               rst,
  input  wire               start,
  input  wire               is_sqrt,
  input  wire [DVD_W-1:0]   dividend,
  input  wire [CNT_W-1:0]   divisor,
  output logic              done,
  output logic [DVD_W-1:0]  quotient,
  output logic [bait_pkg::STD_W-1:0] root
);
  import bait_pkg::*;

  localparam int STEP_W = $clog2(DVD_W + 1);

  logic [STEP_W-1:0] steps;
  logic              sq_mode;
  logic [DVD_W-1:0]  x;
  logic [CNT_W:0]    rem;
  logic [CNT_W-1:0]  dsr;
  logic [STD_W:0]    srem;

  logic [CNT_W:0]   rs;
  logic             ge;
  logic [STD_W+2:0] srs;
  logic [STD_W+2:0] trial;
  logic             sge;

  assign rs    = {rem[CNT_W-1:0], x[DVD_W-1]};
  assign ge    = (rs >= {1'b0, dsr});
  assign srs   = {srem, x[VAR_W-1 -: 2]};
  assign trial = {1'b0, root, 2'b01};
  assign sge   = (srs >= trial);
  assign quotient = x;

  always_ff @(posedge clk) begin
    if (rst) begin
      steps <= '0;
      done  <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        steps <= is_sqrt ? STEP_W'(VAR_W / 2) : STEP_W'(DVD_W);
      end else if (steps != '0) begin
        steps <= steps - 1'b1;
        if (steps == STEP_W'(1)) done <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      sq_mode <= is_sqrt;
      x       <= dividend;
      dsr     <= divisor;
      rem     <= '0;
      srem    <= '0;
      root    <= '0;
    end else if (steps != '0) begin
      if (sq_mode) begin
        x    <= {x[DVD_W-3:0], 2'b00};
        srem <= sge ? STD_W'(srs - trial) : srs[STD_W:0];
        root <= {root[STD_W-2:0], sge};
      end else begin
        rem <= ge ? (rs - {1'b0, dsr}) : rs;
        x   <= {x[DVD_W-2:0], ge};
      end
    end
  end

endmodule

`default_nettype wire

>>> rtl/core/bait_back.sv
// Back end: cell statistics memory, global statistics and the threshold sequencer.
// Uses bait_pkg and bait_arith; takes jobs from the queue, writes the result FIFO.
`default_nettype none

module bait_back #(
  parameter int LAYERS           = bait_pkg::LAYERS_DEF,
  parameter int RANGE_BINS       = bait_pkg::RANGE_BINS_DEF,
  parameter int MAX_FRAME_POINTS = bait_pkg::MAX_FRAME_POINTS_DEF
) (
  input  wire              clk,
  input  wire              rst,
  input  bait_pkg::cfg_t   cfg,
  input  bait_pkg::job_t   q_dout,
  input  wire              q_empty,
  output logic             q_rd,
  output logic             out_wr,
  output bait_pkg::result_t out_din,
  input  wire              out_full
);
  import bait_pkg::*;

  localparam int CELLS  = LAYERS * RANGE_BINS;
  localparam int CELL_W = (CELLS > 1) ? $clog2(CELLS) : 1;
  localparam int CNT_W  = $clog2(MAX_FRAME_POINTS + 1);
  localparam int SUM_W  = CNT_W + 16;
  localparam int SQ_W   = CNT_W + 32;
  localparam int DVD_W  = SQ_W + 16;
  localparam int WORD_W = EPOCH_W + CNT_W + SUM_W + SQ_W;

  back_state_e state, state_next;

  // cell memory word: {epoch tag, count, sum, sum of squares}
  logic [WORD_W-1:0] mem [CELLS];
  logic [WORD_W-1:0] rd_data;
  logic              mem_we;
  logic [CELL_W-1:0] mem_waddr;
  logic [WORD_W-1:0] mem_wdata;

  logic [CELL_W-1:0]  wipe_cnt;
  logic [EPOCH_W-1:0] epoch;
  job_t               cur;

  logic [CNT_W-1:0] g_cnt;
  logic [SUM_W-1:0] g_sum;
  logic [SQ_W-1:0]  g_sq;

  logic [CNT_W-1:0] st_cnt;
  logic [SQ_W-1:0]  st_sq;
  logic             used;
  logic [MEAN_W-1:0] mean;
  logic [VAR_W-1:0]  msq;
  logic [VAR_W-1:0]  m2;
  logic [STD_W-1:0]  stdv;
  logic [KS_W-1:0]   ks;
  logic [THR_W-1:0]  thr;

  logic [EPOCH_W-1:0] b_tag;
  logic [CNT_W-1:0]   b_cnt, base_cnt, sel_cnt;
  logic [SUM_W-1:0]   b_sum, base_sum, sel_sum;
  logic [SQ_W-1:0]    b_sq, base_sq, sel_sq;
  logic               bin_ok, use_bin;
  logic [15:0]        need;
  logic [31:0]        isq;
  logic [VAR_W-1:0]   var_d;
  logic [KS_W-1:0]    margin;
  logic [THR_W-1:0]   thr_sum;
  logic signed [30:0] thr_s, val_s, diff;

  logic             ar_start, ar_sqrt, ar_done;
  logic [DVD_W-1:0] ar_dvd, ar_q;
  logic [CNT_W-1:0] ar_dsr;
  logic [STD_W-1:0] ar_root;

  bait_arith #(.CNT_W(CNT_W), .DVD_W(DVD_W)) u_arith (
    .clk      (clk),
    .rst      (rst),
    .start    (ar_start),
    .is_sqrt  (ar_sqrt),
    .dividend (ar_dvd),
    .divisor  (ar_dsr),
    .done     (ar_done),
    .quotient (ar_q),
    .root     (ar_root)
  );

  always_ff @(posedge clk) begin
    if (mem_we) mem[mem_waddr] <= mem_wdata;
    rd_data <= mem[q_dout.cell_idx[CELL_W-1:0]];
  end

  assign {b_tag, b_cnt, b_sum, b_sq} = rd_data;
  assign bin_ok   = (b_tag == epoch);
  assign base_cnt = bin_ok ? b_cnt : '0;
  assign base_sum = bin_ok ? b_sum : '0;
  assign base_sq  = bin_ok ? b_sq  : '0;
  assign need     = (cfg.min_bin_samples == 16'd0) ? 16'd1 : cfg.min_bin_samples;
  assign use_bin  = bin_ok && (32'(b_cnt) >= 32'(need));
  assign sel_cnt  = use_bin ? b_cnt : g_cnt;
  assign sel_sum  = use_bin ? b_sum : g_sum;
  assign sel_sq   = use_bin ? b_sq  : g_sq;
  assign isq      = 32'(cur.intensity) * 32'(cur.intensity);
  assign var_d    = (msq > m2) ? (msq - m2) : '0;
  assign margin   = (ks > KS_W'(cfg.min_delta)) ? ks : KS_W'(cfg.min_delta);
  assign thr_sum  = THR_W'(mean) + THR_W'(margin);

  always_comb begin
    thr_s = $signed({2'b00, thr});
    if (cfg.boost_enable && cur.reflector) begin
      thr_s = thr_s - $signed({7'd0, cfg.boost_amount});
    end
    val_s = $signed({7'd0, cur.intensity, 8'd0});
    diff  = val_s - thr_s;
  end

  always_comb begin
    state_next = state;
    q_rd       = 1'b0;
    out_wr     = 1'b0;
    mem_we     = 1'b0;
    mem_waddr  = cur.cell_idx[CELL_W-1:0];
    mem_wdata  = '0;
    ar_start   = 1'b0;
    ar_sqrt    = 1'b0;
    ar_dvd     = '0;
    ar_dsr     = st_cnt;
    out_din.passed         = !diff[30];
    out_din.score          = (diff[30] ? SCORE_W'(0)
                             : ((diff[29:25] != '0) ? {SCORE_W{1'b1}} : diff[24:0]));
    out_din.used_bin_stats = used;
    unique case (state)
      B_WIPE: begin
        mem_we    = 1'b1;
        mem_waddr = wipe_cnt;
        if (wipe_cnt == CELL_W'(CELLS - 1)) state_next = B_IDLE;
      end
      B_IDLE: begin
        if (!q_empty && !out_full) begin
          q_rd = 1'b1;
          unique case (q_dout.op)
            OP_CLEAR:              state_next = (epoch == {EPOCH_W{1'b1}}) ? B_WIPE : B_IDLE;
            OP_ACCUM, OP_CLASSIFY: state_next = B_READ;
            OP_NONE:               state_next = B_IDLE;
          endcase
        end
      end
      B_READ: begin
        if (cur.op == OP_ACCUM) begin
          mem_we = 1'b1;
          if (32'(base_cnt) < 32'(MAX_FRAME_POINTS)) begin
            mem_wdata = {epoch, base_cnt + 1'b1, base_sum + SUM_W'(cur.intensity),
                         base_sq + SQ_W'(isq)};
          end else begin
            mem_wdata = {epoch, base_cnt, base_sum, base_sq};
          end
          state_next = B_IDLE;
        end else if (sel_cnt == '0) begin
          state_next = B_KS;
        end else begin
          ar_start   = 1'b1;
          ar_dvd     = DVD_W'({sel_sum, 8'd0});
          ar_dsr     = sel_cnt;
          state_next = B_MEAN;
        end
      end
      B_MEAN: begin
        if (ar_done) begin
          if (32'(st_cnt) < 32'(STD_MIN_COUNT)) begin
            state_next = B_KS;
          end else begin
            ar_start   = 1'b1;
            ar_dvd     = {st_sq, 16'd0};
            state_next = B_MSQ;
          end
        end
      end
      B_MSQ:  if (ar_done) state_next = B_SQR;
      B_SQR:  state_next = B_VAR;
      B_VAR: begin
        if (var_d == '0) begin
          state_next = B_KS;
        end else begin
          ar_start   = 1'b1;
          ar_sqrt    = 1'b1;
          ar_dvd     = DVD_W'(var_d);
          state_next = B_SQRT;
        end
      end
      B_SQRT: if (ar_done) state_next = B_KS;
      B_KS:   state_next = B_THR;
      B_THR:  state_next = B_OUT;
      B_OUT: begin
        out_wr     = 1'b1;
        state_next = B_IDLE;
      end
      default: state_next = B_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= B_WIPE;
      wipe_cnt <= '0;
      epoch    <= EPOCH_W'(1);
      g_cnt    <= '0;
      g_sum    <= '0;
      g_sq     <= '0;
    end else begin
      state <= state_next;
      if (state == B_WIPE) begin
        wipe_cnt <= wipe_cnt + 1'b1;
        epoch    <= EPOCH_W'(1);
      end
      if (state == B_IDLE && q_rd && q_dout.op == OP_CLEAR) begin
        g_cnt    <= '0;
        g_sum    <= '0;
        g_sq     <= '0;
        epoch    <= epoch + 1'b1;
        wipe_cnt <= '0;
      end
      if (state == B_READ && cur.op == OP_ACCUM && 32'(g_cnt) < 32'(MAX_FRAME_POINTS)) begin
        g_cnt <= g_cnt + 1'b1;
        g_sum <= g_sum + SUM_W'(cur.intensity);
        g_sq  <= g_sq + SQ_W'(isq);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state == B_IDLE && q_rd) cur <= q_dout;
    unique case (state)
      B_READ: begin
        st_cnt <= sel_cnt;
        st_sq  <= sel_sq;
        used   <= use_bin;
        mean   <= '0;
        stdv   <= '0;
      end
      B_MEAN: if (ar_done) mean <= ar_q[MEAN_W-1:0];
      B_MSQ:  if (ar_done) msq <= ar_q[VAR_W-1:0];
      B_SQR:  m2 <= VAR_W'(mean) * VAR_W'(mean);
      B_SQRT: if (ar_done) stdv <= ar_root;
      B_KS:   ks <= KS_W'((36'(cfg.stddev_gain) * 36'(stdv)) >> 8);
      B_THR:  thr <= (32'(thr_sum) < 32'(cfg.intensity_floor))
                     ? THR_W'(cfg.intensity_floor) : thr_sum;
      default: ;
    endcase
  end

endmodule

`default_nettype wire

>>> rtl/core/binned_adaptive_intensity_threshold.sv
// Top level of the binned adaptive intensity threshold: config registers, front end,
// job queue, back end and result FIFO. Uses bait_pkg, bait_front, bait_fifo, bait_back.
`default_nettype none

// Bright-point selector over one lidar frame. Push items in: clear starts a frame,
// accumulate adds a point to global and per (layer, range bin) statistics, classify
// returns one result (threshold = mean + max(min_delta, k*sigma), floored, less the
// reflector boost). The front end runs a bit-serial range/bin-size divide for each
// accumulate or classify item and skips it for a clear. In the back end an accumulate
// is a memory read, then a write; a classify runs mean and mean-square divides and a
// square root, as the statistics need them, on one shared iterative unit, so classify
// throughput is set by that unit. After reset, and after every 255th clear, the back
// end retags the cell memory, one statistics cell (512 at default geometry) per cycle,
// before taking work.
module binned_adaptive_intensity_threshold #(
  parameter int LAYERS           = bait_pkg::LAYERS_DEF,
  parameter int RANGE_BINS       = bait_pkg::RANGE_BINS_DEF,
  parameter int MAX_FRAME_POINTS = bait_pkg::MAX_FRAME_POINTS_DEF
) (
  input  wire                               clk,
  input  wire                               rst,
  input  wire                               push,
  output logic                              full,
  input  bait_pkg::item_t                   item,
  output logic                              empty,
  input  wire                               pop,
  output bait_pkg::result_t                 result,
  input  wire                               cfg_wr,
  input  wire  [bait_pkg::CFG_ADDR_W-1:0]   cfg_addr,
  input  wire  [bait_pkg::CFG_DATA_W-1:0]   cfg_data
);
  import bait_pkg::*;

  cfg_t    cfg;
  logic    q_wr, q_full, q_rd, q_empty;
  job_t    q_din, q_dout;
  logic    out_wr, out_full;
  result_t out_din;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.range_bin_size_mm <= RST_RANGE_BIN_SIZE;
      cfg.stddev_gain       <= RST_STDDEV_GAIN;
      cfg.min_delta         <= RST_MIN_DELTA;
      cfg.min_bin_samples   <= RST_MIN_BIN_SAMP;
      cfg.intensity_floor   <= RST_FLOOR;
      cfg.bin_by_layer      <= RST_BIN_BY_LAYER;
      cfg.boost_enable      <= RST_BOOST_EN;
      cfg.boost_amount      <= RST_BOOST_AMOUNT;
    end else if (cfg_wr) begin
      unique case (cfg_reg_e'(cfg_addr))
        REG_RANGE_BIN_SIZE: cfg.range_bin_size_mm <= cfg_data[15:0];
        REG_STDDEV_GAIN:    cfg.stddev_gain       <= cfg_data[11:0];
        REG_MIN_DELTA:      cfg.min_delta         <= cfg_data;
        REG_MIN_BIN_SAMP:   cfg.min_bin_samples   <= cfg_data[15:0];
        REG_FLOOR:          cfg.intensity_floor   <= cfg_data;
        REG_BIN_BY_LAYER:   cfg.bin_by_layer      <= cfg_data[0];
        REG_BOOST_EN:       cfg.boost_enable      <= cfg_data[0];
        REG_BOOST_AMOUNT:   cfg.boost_amount      <= cfg_data;
      endcase
    end
  end

  bait_front #(.LAYERS(LAYERS), .RANGE_BINS(RANGE_BINS)) u_front (
    .clk    (clk),
    .rst    (rst),
    .push   (push),
    .full   (full),
    .item   (item),
    .cfg    (cfg),
    .q_wr   (q_wr),
    .q_din  (q_din),
    .q_full (q_full)
  );

  bait_fifo #(.T(job_t), .DEPTH(QUEUE_DEPTH)) u_jobq (
    .clk   (clk),
    .rst   (rst),
    .wr_en (q_wr),
    .din   (q_din),
    .full  (q_full),
    .rd_en (q_rd),
    .dout  (q_dout),
    .empty (q_empty)
  );

  bait_back #(
    .LAYERS           (LAYERS),
    .RANGE_BINS       (RANGE_BINS),
    .MAX_FRAME_POINTS (MAX_FRAME_POINTS)
  ) u_back (
    .clk      (clk),
    .rst      (rst),
    .cfg      (cfg),
    .q_dout   (q_dout),
    .q_empty  (q_empty),
    .q_rd     (q_rd),
    .out_wr   (out_wr),
    .out_din  (out_din),
    .out_full (out_full)
  );

  bait_fifo #(.T(result_t), .DEPTH(OUT_DEPTH)) u_outq (
    .clk   (clk),
    .rst   (rst),
    .wr_en (out_wr),
    .din   (out_din),
    .full  (out_full),
    .rd_en (pop),
    .dout  (result),
    .empty (empty)
  );

endmodule

`default_nettype wire

>>> bench/binned_adaptive_intensity_threshold_test.sv
// Testbench for binned_adaptive_intensity_threshold: directed and random frames,
// checked against a built-in fixed-point predictor. Depends on bait_pkg and the RTL.
`timescale 1ns / 1ps

import bait_pkg::*;

class threshold_scoreboard;
  localparam int NCELL = RANGE_BINS_DEF * LAYERS_DEF;
  localparam int GLB = NCELL;   // global stats live past the cells

  logic [23:0] regs [8];
  longint unsigned cnt [NCELL + 1];
  longint unsigned sum [NCELL + 1];
  longint unsigned sq [NCELL + 1];
  bit cell_ok [NCELL];
  result_t want_q [$];
  int errors;

  function new();
    errors = 0;
    regs[REG_RANGE_BIN_SIZE] = RST_RANGE_BIN_SIZE;
    regs[REG_STDDEV_GAIN]    = RST_STDDEV_GAIN;
    regs[REG_MIN_DELTA]      = RST_MIN_DELTA;
    regs[REG_MIN_BIN_SAMP]   = RST_MIN_BIN_SAMP;
    regs[REG_FLOOR]          = RST_FLOOR;
    regs[REG_BIN_BY_LAYER]   = RST_BIN_BY_LAYER;
    regs[REG_BOOST_EN]       = RST_BOOST_EN;
    regs[REG_BOOST_AMOUNT]   = RST_BOOST_AMOUNT;
    wipe();
  endfunction

  function void wipe();
    for (int i = 0; i <= NCELL; i++) begin
      cnt[i] = 0; sum[i] = 0; sq[i] = 0;
      if (i < NCELL) cell_ok[i] = 0;
    end
  endfunction

  function void set_reg(cfg_reg_e r, logic [23:0] v);
    case (r)
      REG_RANGE_BIN_SIZE, REG_MIN_BIN_SAMP: regs[r] = v & 24'hFFFF;
      REG_STDDEV_GAIN: regs[r] = v & 24'hFFF;
      REG_BIN_BY_LAYER, REG_BOOST_EN: regs[r] = v & 24'h1;
      default: regs[r] = v;
    endcase
  endfunction

  function void add(int i, longint unsigned x);
    if (cnt[i] >= MAX_FRAME_POINTS_DEF) return;
    cnt[i]++;
    sum[i] += x;
    sq[i] += x * x;
  endfunction

  function longint unsigned mean_q8(int i);
    return (cnt[i] == 0) ? 0 : (sum[i] << 8) / cnt[i];
  endfunction

  function longint unsigned root(longint unsigned v);
    longint unsigned res, b;
    res = 0;
    b = 64'd1 << 62;
    while (b > v) b >>= 2;
    while (b != 0) begin
      if (v >= res + b) begin
        v -= res + b;
        res = (res >> 1) + b;
      end else res >>= 1;
      b >>= 2;
    end
    return res;
  endfunction

  function longint unsigned sigma_q8(int i);
    longint unsigned m, msq;
    if (cnt[i] < STD_MIN_COUNT) return 0;
    m = mean_q8(i);
    msq = ((sq[i] / cnt[i]) << 16) + (((sq[i] % cnt[i]) << 16) / cnt[i]);
    return (msq <= m * m) ? 0 : root(msq - m * m);
  endfunction

  // accepted input: update frame stats, queue the expected result of a classify
  function void note(item_t it);
    longint unsigned size, rb, lb, need, ks, margin;
    longint thr, val;
    int c, st;
    result_t r;
    if (it.opcode == OP_CLEAR) begin
      wipe();
      return;
    end
    if (it.opcode == OP_NONE) return;
    size = (regs[REG_RANGE_BIN_SIZE] < MIN_BIN_MM) ? MIN_BIN_MM : regs[REG_RANGE_BIN_SIZE];
    rb = it.range_mm / size;
    if (rb > RANGE_BINS_DEF - 1) rb = RANGE_BINS_DEF - 1;
    lb = (regs[REG_BIN_BY_LAYER][0] && it.layer_known) ? it.layer : 0;
    c = int'(lb * RANGE_BINS_DEF + rb);
    if (it.opcode == OP_ACCUM) begin
      if (!cell_ok[c]) begin
        cnt[c] = 0; sum[c] = 0; sq[c] = 0;
        cell_ok[c] = 1;
      end
      add(GLB, it.intensity);
      add(c, it.intensity);
      return;
    end
    need = (regs[REG_MIN_BIN_SAMP] == 0) ? 1 : regs[REG_MIN_BIN_SAMP];
    st = (cell_ok[c] && cnt[c] >= need) ? c : GLB;
    ks = (regs[REG_STDDEV_GAIN] * sigma_q8(st)) >> 8;
    margin = (ks > regs[REG_MIN_DELTA]) ? ks : regs[REG_MIN_DELTA];
    thr = longint'(mean_q8(st) + margin);
    if (thr < longint'(regs[REG_FLOOR])) thr = regs[REG_FLOOR];
    if (regs[REG_BOOST_EN][0] && it.reflector) thr -= longint'(regs[REG_BOOST_AMOUNT]);
    val = longint'(it.intensity) << 8;
    r.used_bin_stats = (st != GLB);
    if (val >= thr) begin
      r.passed = 1;
      r.score = (val - thr > 33554431) ? 25'h1FFFFFF : SCORE_W'(val - thr);
    end else begin
      r.passed = 0;
      r.score = 0;
    end
    want_q = {want_q, r};
  endfunction

  function void check(result_t got);
    result_t w;
    if (want_q.size() == 0) begin
      $error("unexpected result %p", got);
      errors++;
      return;
    end
    w = want_q.pop_front();
    if (got.passed !== w.passed) begin
      $error("passed: expected %0d, got %0d", w.passed, got.passed);
      errors++;
    end
    if (got.score !== w.score) begin
      $error("score: expected %0d, got %0d", w.score, got.score);
      errors++;
    end
    if (got.used_bin_stats !== w.used_bin_stats) begin
      $error("used_bin_stats: expected %0d, got %0d", w.used_bin_stats, got.used_bin_stats);
      errors++;
    end
  endfunction
endclass

module binned_adaptive_intensity_threshold_test;
  logic clk = 0;
  logic rst = 1;
  logic push = 0;
  logic full;
  item_t item = '0;
  logic empty;
  logic pop = 0;
  result_t result;
  logic cfg_wr = 0;
  logic [CFG_ADDR_W-1:0] cfg_addr = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  threshold_scoreboard sb = new();
  int hold_left = 0;
  int burst_left = 0;
  logic [15:0] hot_range [4];
  logic [4:0] hot_layer [4];

  binned_adaptive_intensity_threshold dut (
    .clk(clk), .rst(rst), .push(push), .full(full), .item(item),
    .empty(empty), .pop(pop), .result(result),
    .cfg_wr(cfg_wr), .cfg_addr(cfg_addr), .cfg_data(cfg_data)
  );

  always begin
    #6 clk = 1;
    #6 clk = 0;
  end

  initial begin
    #30_000_000;
    $display("binned_adaptive_intensity_threshold test failed");
    $finish;
  end

  // receiver: own stall pattern plus a long hold-off on request
  always @(posedge clk) begin
    if (!rst) begin
      if (pop && !empty) sb.check(result);
      if (hold_left > 0) begin
        hold_left <= hold_left - 1;
        pop <= 0;
      end else if (($time / 3000) % 4 == 0) begin
        pop <= 1;  // stretch with no stalls
      end else begin
        pop <= ($urandom_range(0, 9) < 6);
      end
    end
  end

  task automatic send(item_t it);
    push <= 1;
    item <= it;
    @(posedge clk);
    while (full) @(posedge clk);
    sb.note(it);
  endtask

  task automatic offer(item_t it);
    if (burst_left == 0) begin
      if ($urandom_range(0, 3) != 0) begin
        push <= 0;
        repeat ($urandom_range(1, 15)) @(posedge clk);
      end
      burst_left = $urandom_range(1, 30);
    end
    burst_left--;
    send(it);
  endtask

  task automatic drain();
    push <= 0;
    burst_left = 0;
    @(posedge clk);
    while (sb.want_q.size() != 0) @(posedge clk);
    repeat (700) @(posedge clk);  // covers trailing accumulates and a retag pass
  endtask

  task automatic write_reg(cfg_reg_e r, logic [23:0] v);
    cfg_wr <= 1;
    cfg_addr <= r;
    cfg_data <= v;
    @(posedge clk);
    cfg_wr <= 0;
    sb.set_reg(r, v);
  endtask

  task automatic write_all(logic [23:0] sz, logic [23:0] k, logic [23:0] dl, logic [23:0] mn,
                           logic [23:0] fl, logic [23:0] byl, logic [23:0] be,
                           logic [23:0] ba);
    write_reg(REG_RANGE_BIN_SIZE, sz);
    write_reg(REG_STDDEV_GAIN, k);
    write_reg(REG_MIN_DELTA, dl);
    write_reg(REG_MIN_BIN_SAMP, mn);
    write_reg(REG_FLOOR, fl);
    write_reg(REG_BIN_BY_LAYER, byl);
    write_reg(REG_BOOST_EN, be);
    write_reg(REG_BOOST_AMOUNT, ba);
  endtask

  function automatic item_t mk(op_e op, logic [15:0] inten, logic [15:0] rng,
                               logic [4:0] lay, logic kn, logic refl);
    item_t it;
    it.opcode = op;
    it.intensity = inten;
    it.range_mm = rng;
    it.layer = lay;
    it.layer_known = kn;
    it.reflector = refl;
    return it;
  endfunction

  // frame: clear, then mostly accumulates and classifies on a few hot cells
  task automatic run_frame(int n);
    int base, spread, h, k;
    op_e op;
    item_t it;
    base = $urandom_range(0, 65535);
    case ($urandom_range(0, 3))
      0: spread = 0;
      1: spread = 20;
      2: spread = 2000;
      default: spread = 65535;
    endcase
    for (int j = 0; j < 4; j++) begin
      hot_range[j] = ($urandom_range(0, 7) == 0) ? 16'($urandom) : 16'($urandom_range(0, 4000));
      hot_layer[j] = 5'($urandom);
    end
    offer(mk(OP_CLEAR, 16'($urandom), 16'($urandom), 5'($urandom), 1'($urandom),
             1'($urandom)));
    for (int i = 0; i < n; i++) begin
      k = $urandom_range(0, 99);
      op = (k < 60) ? OP_ACCUM : (k < 95) ? OP_CLASSIFY : (k < 98) ? OP_NONE : OP_CLEAR;
      h = $urandom_range(0, 3);
      it = mk(op, 16'(base + $urandom_range(0, spread)), hot_range[h], hot_layer[h],
              ($urandom_range(0, 7) != 0), 1'($urandom));
      if ($urandom_range(0, 9) == 0) begin
        it.intensity = 16'($urandom);
        it.range_mm = 16'($urandom);
        it.layer = 5'($urandom);
      end
      offer(it);
    end
  endtask

  initial begin
    repeat (8) @(posedge clk);
    rst <= 0;

    // directed, reset settings
    send(mk(OP_CLASSIFY, 16'd0, 16'd0, 5'd0, 1'b0, 1'b0));          // empty stats
    send(mk(OP_CLASSIFY, 16'd65535, 16'd65535, 5'd31, 1'b1, 1'b1));
    send(mk(OP_ACCUM, 16'd65535, 16'd100, 5'd3, 1'b1, 1'b0));
    send(mk(OP_CLASSIFY, 16'd100, 16'd100, 5'd3, 1'b1, 1'b1));      // single point
    send(mk(OP_ACCUM, 16'd0, 16'd100, 5'd3, 1'b1, 1'b0));
    send(mk(OP_ACCUM, 16'd0, 16'd65535, 5'd31, 1'b1, 1'b0));        // last range bin
    send(mk(OP_ACCUM, 16'd40000, 16'd65535, 5'd31, 1'b0, 1'b0));    // layer absent
    send(mk(OP_NONE, 16'hFFFF, 16'hFFFF, 5'd31, 1'b1, 1'b1));       // ignored opcode
    send(mk(OP_CLASSIFY, 16'd32768, 16'd100, 5'd3, 1'b1, 1'b0));
    send(mk(OP_CLASSIFY, 16'd65535, 16'd65535, 5'd31, 1'b0, 1'b1));
    send(mk(OP_CLEAR, 16'd0, 16'd0, 5'd0, 1'b0, 1'b0));
    send(mk(OP_CLASSIFY, 16'd1, 16'd100, 5'd3, 1'b1, 1'b0));
    drain();

    // tiny bin size, zero sample minimum, largest gain and boost
    write_all(24'd0, 24'd4095, 24'd0, 24'd0, 24'd0, 24'd0, 24'd1, 24'hFFFFFF);
    send(mk(OP_ACCUM, 16'd1000, 16'd49, 5'd7, 1'b1, 1'b0));
    send(mk(OP_ACCUM, 16'd3000, 16'd10, 5'd9, 1'b1, 1'b0));
    send(mk(OP_CLASSIFY, 16'd2000, 16'd0, 5'd1, 1'b1, 1'b0));       // bin with two points
    send(mk(OP_CLASSIFY, 16'd0, 16'd50, 5'd1, 1'b0, 1'b1));
    send(mk(OP_CLASSIFY, 16'd65535, 16'd20, 5'd0, 1'b1, 1'b1));
    run_frame(200);
    drain();

    // opposite extremes
    write_all(24'd65535, 24'd0, 24'hFFFFFF, 24'd65535, 24'hFFFFFF, 24'd1, 24'd0, 24'd0);
    run_frame(150);
    drain();

    write_all(24'd50, 24'd256, 24'd100, 24'd3, 24'd20000, 24'd1, 24'd1, 24'd3000);
    run_frame(120);
    // the block fills while results are held back
    push <= 0;
    @(posedge clk);
    hold_left = 600;
    for (int i = 0; i < 30; i++)
      send(mk(($urandom_range(0, 2) == 0) ? OP_ACCUM : OP_CLASSIFY, 16'($urandom),
              16'($urandom_range(0, 800)), 5'($urandom_range(0, 1)), 1'b1, 1'($urandom)));
    run_frame(60);
    // sender waits for every result mid-phase
    push <= 0;
    @(posedge clk);
    while (sb.want_q.size() != 0) @(posedge clk);
    run_frame(60);
    drain();

    for (int p = 0; p < 5; p++) begin
      write_all(24'($urandom_range(0, 3000)), 24'($urandom_range(0, 4095)),
                ($urandom_range(0, 3) == 0) ? 24'($urandom) : 24'($urandom_range(0, 5000)),
                24'($urandom_range(0, 10)),
                ($urandom_range(0, 2) == 0) ? 24'($urandom) : 24'($urandom_range(0, 3000)),
                24'($urandom_range(0, 1)), 24'($urandom_range(0, 1)), 24'($urandom));
      for (int f = 0; f < 4; f++) run_frame($urandom_range(30, 80));
      drain();
    end

    if (sb.errors == 0 && sb.want_q.size() == 0)
      $display("binned_adaptive_intensity_threshold test passed");
    else
      $display("binned_adaptive_intensity_threshold test failed");
    $finish;
  end
endmodule
